>>> sv/pps_pkg.sv
// shared types, codes and constants for the priority preempt state sequencer
// no dependencies; every other file takes names from here by scope or by import
package pps_pkg;

    // default values for the top level parameters
    localparam int NUM_STATES_DEF      = 8;
    localparam int NUM_TRANSITIONS_DEF = 8;
    localparam int PRIORITY_BITS_DEF   = 4;

    // fixed field and register widths
    localparam int STATE_W       = 3;
    localparam int MODE_W        = 4;
    localparam int PRED_W        = 8;
    localparam int PRIO_REG_W    = 32;
    localparam int PRESENT_W     = 8;
    localparam int TRANS_REG_W   = 36;
    localparam int COUNT_W       = 4;
    localparam int TABLE_ENTRIES = 8;
    localparam int ENTRY_BITS    = 9;
    localparam int CFG_ADDR_W    = 6;
    localparam int CFG_DATA_W    = 64;

    // mode code meaning no state chosen yet
    localparam logic [MODE_W-1:0] NO_MODE = 4'd8;

    // item function codes
    localparam logic FUNC_REQUEST = 1'b0;
    localparam logic FUNC_TICK    = 1'b1;

    // register index, taken from the 8-byte aligned address
    typedef enum logic [2:0] {
        REG_PRIORITIES = 3'd0,
        REG_PRESENT    = 3'd1,
        REG_TRANS_LOW  = 3'd2,
        REG_TRANS_HIGH = 3'd3,
        REG_COUNT      = 3'd4
    } pps_reg_t;

    // transition condition codes
    typedef enum logic [1:0] {
        COND_ALWAYS   = 2'd0,
        COND_FINISHED = 2'd1,
        COND_PRIORITY = 2'd2,
        COND_NEVER    = 2'd3
    } pps_cond_t;

    // one transition entry, laid out as in the table registers
    typedef struct packed {
        logic                 gated;
        pps_cond_t            cond;
        logic [STATE_W-1:0]   to;
        logic [STATE_W-1:0]   from;
    } pps_entry_t;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [PRIO_REG_W-1:0]  priorities;
        logic [PRESENT_W-1:0]   present;
        logic [TRANS_REG_W-1:0] trans_low;
        logic [TRANS_REG_W-1:0] trans_high;
        logic [COUNT_W-1:0]     count;
    } pps_cfg_t;

    // operands handed to the shared evaluation unit
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              match_from;
        pps_entry_t        entry;
        logic              pred;
        logic              finished;
    } pps_eval_req_t;

    // verdict of the shared evaluation unit
    typedef struct packed {
        logic to_present;
        logic allows;
        logic go;
    } pps_eval_rsp_t;

endpackage

>>> sv/pps_item_if.sv
// input channel carrying request and tick items
// depends on pps_pkg for field widths
interface pps_item_if;
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [pps_pkg::STATE_W-1:0]  target_state;
    logic                         force_request;
    logic                         anim_finished;
    logic [pps_pkg::PRED_W-1:0]   predicate_ok;

    modport source (
        output valid, func, target_state, force_request, anim_finished, predicate_ok,
        input  ready
    );
    modport sink (
        input  valid, func, target_state, force_request, anim_finished, predicate_ok,
        output ready
    );
endinterface

>>> sv/pps_result_if.sv
// output channel carrying one result per item
// depends on pps_pkg for field widths
interface pps_result_if;
    logic                         valid;
    logic                         ready;
    logic [pps_pkg::MODE_W-1:0]   active_state;
    logic                         restart_animation;
    logic                         pending_valid;
    logic [pps_pkg::STATE_W-1:0]  queued_state;

    modport source (
        output valid, active_state, restart_animation, pending_valid, queued_state,
        input  ready
    );
    modport sink (
        input  valid, active_state, restart_animation, pending_valid, queued_state,
        output ready
    );
endinterface

>>> sv/pps_cfg_regs.sv
// apb-style configuration registers: priorities, presence, transition table, count
// depends on pps_pkg for the register map and the configuration struct
module pps_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pps_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [pps_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [pps_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output pps_pkg::pps_cfg_t              cfg
);

    pps_pkg::pps_cfg_t cfg_reg;
    pps_pkg::pps_cfg_t cfg_next;
    pps_pkg::pps_reg_t reg_sel;
    logic              wr_en;

    assign pready  = 1'b1;
    assign reg_sel = pps_pkg::pps_reg_t'(paddr[pps_pkg::CFG_ADDR_W-1:3]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    // write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                pps_pkg::REG_PRIORITIES:
                    cfg_next.priorities = pwdata[pps_pkg::PRIO_REG_W-1:0];
                pps_pkg::REG_PRESENT:
                    cfg_next.present = pwdata[pps_pkg::PRESENT_W-1:0];
                pps_pkg::REG_TRANS_LOW:
                    cfg_next.trans_low = pwdata[pps_pkg::TRANS_REG_W-1:0];
                pps_pkg::REG_TRANS_HIGH:
                    cfg_next.trans_high = pwdata[pps_pkg::TRANS_REG_W-1:0];
                pps_pkg::REG_COUNT:
                    cfg_next.count = pwdata[pps_pkg::COUNT_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    // read back
    always_comb
    begin
        unique case (reg_sel)
            pps_pkg::REG_PRIORITIES:
                prdata = pps_pkg::CFG_DATA_W'(cfg_reg.priorities);
            pps_pkg::REG_PRESENT:
                prdata = pps_pkg::CFG_DATA_W'(cfg_reg.present);
            pps_pkg::REG_TRANS_LOW:
                prdata = pps_pkg::CFG_DATA_W'(cfg_reg.trans_low);
            pps_pkg::REG_TRANS_HIGH:
                prdata = pps_pkg::CFG_DATA_W'(cfg_reg.trans_high);
            pps_pkg::REG_COUNT:
                prdata = pps_pkg::CFG_DATA_W'(cfg_reg.count);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> sv/pps_eval_unit.sv
// shared evaluation unit: presence, priority lookup and compare, transition verdict
// depends on pps_pkg for the entry, configuration and operand structs
module pps_eval_unit #(
    parameter int NUM_STATES    = pps_pkg::NUM_STATES_DEF,
    parameter int PRIORITY_BITS = pps_pkg::PRIORITY_BITS_DEF
) (
    input  pps_pkg::pps_cfg_t      cfg,
    input  pps_pkg::pps_eval_req_t req,
    output pps_pkg::pps_eval_rsp_t rsp
);

    localparam int EXT_W = pps_pkg::PRIO_REG_W + PRIORITY_BITS;

    // state defined, within the table and the configured state count
    function automatic logic is_present(input logic [pps_pkg::MODE_W-1:0] s,
                                        input logic [pps_pkg::PRESENT_W-1:0] mask);
        logic in_range;
        in_range   = (int'(s) < pps_pkg::TABLE_ENTRIES) && (int'(s) < NUM_STATES);
        is_present = in_range && mask[s[pps_pkg::STATE_W-1:0]];
    endfunction

    // priority of a state; absent states and bits past the register read as zero
    function automatic logic [PRIORITY_BITS-1:0] prio_of(
        input logic [pps_pkg::MODE_W-1:0]     s,
        input logic [pps_pkg::PRESENT_W-1:0]  mask,
        input logic [pps_pkg::PRIO_REG_W-1:0] prio);
        logic [5:0]       sh;
        logic [EXT_W-1:0] ext;
        sh  = {3'b000, s[pps_pkg::STATE_W-1:0]} * 6'(PRIORITY_BITS);
        ext = {{PRIORITY_BITS{1'b0}}, prio};
        if (!is_present(s, mask) || sh >= 6'(pps_pkg::PRIO_REG_W))
        begin
            prio_of = '0;
        end
        else
        begin
            prio_of = ext[sh +: PRIORITY_BITS];
        end
    endfunction

    logic [pps_pkg::MODE_W-1:0] to_mode;
    logic [PRIORITY_BITS-1:0]   to_prio;
    logic [PRIORITY_BITS-1:0]   cur_prio;
    logic                       from_ok;
    logic                       gate_ok;
    logic                       cond_ok;

    assign to_mode  = {1'b0, req.entry.to};
    assign to_prio  = prio_of(to_mode, cfg.present, cfg.priorities);
    assign cur_prio = prio_of(req.mode, cfg.present, cfg.priorities);

    // priority compare against the current mode
    assign rsp.to_present = is_present(to_mode, cfg.present);
    assign rsp.allows     = rsp.to_present && (to_prio >= cur_prio);

    // transition verdict
    assign from_ok = !req.match_from || (req.mode == {1'b0, req.entry.from});
    assign gate_ok = !req.entry.gated || req.pred;

    always_comb
    begin
        case (req.entry.cond)
            pps_pkg::COND_ALWAYS:   cond_ok = 1'b1;
            pps_pkg::COND_FINISHED: cond_ok = req.finished;
            pps_pkg::COND_PRIORITY: cond_ok = rsp.allows;
            default:                cond_ok = 1'b0;
        endcase
    end

    assign rsp.go = from_ok && gate_ok && cond_ok;

endmodule

>>> sv/pps_seq.sv
// sequencer: holds mode and queue, steps the transition scan one entry per cycle
// depends on pps_pkg, the item and result interfaces and the shared evaluation unit
module pps_seq #(
    parameter int NUM_TRANSITIONS = pps_pkg::NUM_TRANSITIONS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    pps_item_if.sink               item,
    pps_result_if.source           result,
    input  pps_pkg::pps_cfg_t      cfg,
    output pps_pkg::pps_eval_req_t ev_req,
    input  pps_pkg::pps_eval_rsp_t ev_rsp
);

    localparam int SCAN_MAX = (NUM_TRANSITIONS < pps_pkg::TABLE_ENTRIES) ?
                              NUM_TRANSITIONS : pps_pkg::TABLE_ENTRIES;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SCAN,
        ST_FINISH,
        ST_EMIT
    } state_t;

    state_t                         state_reg, state_next;
    logic [2:0]                     k_reg, k_next;
    logic [pps_pkg::COUNT_W-1:0]    limit_reg, limit_next;
    logic                           fin_reg, fin_next;
    logic [pps_pkg::PRED_W-1:0]     pred_reg, pred_next;
    logic [pps_pkg::STATE_W-1:0]    target_reg, target_next;
    logic                           force_reg, force_next;
    logic [pps_pkg::MODE_W-1:0]     mode_reg, mode_next;
    logic                           pend_reg, pend_next;
    logic [pps_pkg::STATE_W-1:0]    ptgt_reg, ptgt_next;
    logic                           restart_reg, restart_next;
    logic                           out_valid_reg, out_valid_next;
    logic [pps_pkg::MODE_W-1:0]     out_mode_reg, out_mode_next;
    logic                           out_restart_reg, out_restart_next;
    logic                           out_pend_reg, out_pend_next;
    logic [pps_pkg::STATE_W-1:0]    out_queued_reg, out_queued_next;

    pps_pkg::pps_entry_t            entries [pps_pkg::TABLE_ENTRIES];
    logic [2*pps_pkg::TRANS_REG_W-1:0] tbl;
    logic [pps_pkg::COUNT_W-1:0]    limit_cfg;
    logic                           accept;
    logic                           last_entry;
    logic                           out_free;

    // transition table as entries
    assign tbl = {cfg.trans_high, cfg.trans_low};
    always_comb
    begin
        for (int i = 0; i < pps_pkg::TABLE_ENTRIES; i++)
        begin
            entries[i] = pps_pkg::pps_entry_t'(tbl[i*pps_pkg::ENTRY_BITS +: pps_pkg::ENTRY_BITS]);
        end
    end

    // scan length clamped to the table and the parameter
    assign limit_cfg = (int'(cfg.count) > SCAN_MAX) ?
                       pps_pkg::COUNT_W'(SCAN_MAX) : cfg.count;

    assign item.ready = (state_reg == ST_IDLE);
    assign accept     = item.valid && item.ready;
    assign last_entry = (({1'b0, k_reg} + 4'd1) == limit_reg);
    assign out_free   = !out_valid_reg || result.ready;

    // operands for the shared unit: priority check for a request, entry k for a scan
    always_comb
    begin
        ev_req.mode = mode_reg;
        if (state_reg == ST_SCAN)
        begin
            ev_req.match_from = 1'b1;
            ev_req.entry      = entries[k_reg];
            ev_req.pred       = pred_reg[k_reg];
            ev_req.finished   = fin_reg;
        end
        else
        begin
            ev_req.match_from = 1'b0;
            ev_req.entry      = '{gated: 1'b0, cond: pps_pkg::COND_PRIORITY,
                                  to: target_reg, from: '0};
            ev_req.pred       = 1'b0;
            ev_req.finished   = 1'b0;
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next       = state_reg;
        k_next           = k_reg;
        limit_next       = limit_reg;
        fin_next         = fin_reg;
        pred_next        = pred_reg;
        target_next      = target_reg;
        force_next       = force_reg;
        mode_next        = mode_reg;
        pend_next        = pend_reg;
        ptgt_next        = ptgt_reg;
        restart_next     = restart_reg;
        out_valid_next   = out_valid_reg && !result.ready;
        out_mode_next    = out_mode_reg;
        out_restart_next = out_restart_reg;
        out_pend_next    = out_pend_reg;
        out_queued_next  = out_queued_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    target_next  = item.target_state;
                    force_next   = item.force_request;
                    fin_next     = item.anim_finished;
                    pred_next    = item.predicate_ok;
                    restart_next = 1'b0;
                    k_next       = '0;
                    limit_next   = limit_cfg;
                    if (item.func == pps_pkg::FUNC_REQUEST)
                    begin
                        state_next = ST_EVAL;
                    end
                    else if (limit_cfg == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_EVAL:
            begin
                // absent targets and unforced same-state requests are dropped
                if (ev_rsp.to_present && !(mode_reg == {1'b0, target_reg} && !force_reg))
                begin
                    if (force_reg)
                    begin
                        mode_next    = {1'b0, target_reg};
                        restart_next = 1'b1;
                        pend_next    = 1'b0;
                        ptgt_next    = '0;
                    end
                    else if (!ev_rsp.allows)
                    begin
                        pend_next = 1'b1;
                        ptgt_next = target_reg;
                    end
                    else
                    begin
                        mode_next    = {1'b0, target_reg};
                        restart_next = 1'b1;
                    end
                end
                state_next = ST_EMIT;
            end

            ST_SCAN:
            begin
                // first matching entry wins and ends the scan
                if (ev_rsp.go)
                begin
                    mode_next    = {1'b0, ev_req.entry.to};
                    restart_next = 1'b1;
                    state_next   = ST_EMIT;
                end
                else if (last_entry)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    k_next = k_reg + 3'd1;
                end
            end

            ST_FINISH:
            begin
                // queued request fires once the animation is done
                if (pend_reg && fin_reg)
                begin
                    mode_next    = {1'b0, ptgt_reg};
                    restart_next = 1'b1;
                    pend_next    = 1'b0;
                    ptgt_next    = '0;
                end
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_mode_next    = mode_reg;
                    out_restart_next = restart_reg;
                    out_pend_next    = pend_reg;
                    out_queued_next  = pend_reg ? ptgt_reg : '0;
                    state_next       = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            k_reg           <= '0;
            limit_reg       <= '0;
            fin_reg         <= 1'b0;
            pred_reg        <= '0;
            target_reg      <= '0;
            force_reg       <= 1'b0;
            mode_reg        <= pps_pkg::NO_MODE;
            pend_reg        <= 1'b0;
            ptgt_reg        <= '0;
            restart_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_mode_reg    <= pps_pkg::NO_MODE;
            out_restart_reg <= 1'b0;
            out_pend_reg    <= 1'b0;
            out_queued_reg  <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            k_reg           <= k_next;
            limit_reg       <= limit_next;
            fin_reg         <= fin_next;
            pred_reg        <= pred_next;
            target_reg      <= target_next;
            force_reg       <= force_next;
            mode_reg        <= mode_next;
            pend_reg        <= pend_next;
            ptgt_reg        <= ptgt_next;
            restart_reg     <= restart_next;
            out_valid_reg   <= out_valid_next;
            out_mode_reg    <= out_mode_next;
            out_restart_reg <= out_restart_next;
            out_pend_reg    <= out_pend_next;
            out_queued_reg  <= out_queued_next;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.active_state      = out_mode_reg;
    assign result.restart_animation = out_restart_reg;
    assign result.pending_valid     = out_pend_reg;
    assign result.queued_state      = out_queued_reg;

    // checks on the sequencer
    a_queue_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !pend_reg |-> (ptgt_reg == '0))
        else $error("queued target not cleared with the queue");

    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg <= pps_pkg::NO_MODE)
        else $error("mode holds an undefined code");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> ({1'b0, k_reg} < limit_reg))
        else $error("scan index past the configured count");

    a_request_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.func == pps_pkg::FUNC_REQUEST) |=> (state_reg == ST_EVAL))
        else $error("accepted request not evaluated next cycle");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_free) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("result not loaded on emit");

endmodule

>>> sv/priority_preempt_state_sequencer.sv
// top level of the priority preempt state sequencer
// depends on pps_pkg, pps_item_if, pps_result_if, pps_cfg_regs, pps_eval_unit, pps_seq
//
//  channel   direction  handshake          payload
//  item      in         valid/ready        func, target_state, force_request,
//                                          anim_finished, predicate_ok
//  result    out        valid/ready        active_state, restart_animation,
//                                          pending_valid, queued_state
//  config    in         psel/penable, apb  paddr, pwdata, prdata (64-bit, 8-byte stride)
//
// a request passes through accept, priority check and load of the output register, in
// that order; the load waits while the output register holds a result not yet taken
// a frame tick scans up to n table entries, n the clamped transition count (at most 8),
// stepping one table entry per cycle through the shared evaluation unit; a transition
// that fires ends the scan early
// reset is asynchronous: mode reads none (8), queue empty, all other registers zero
// a waiting result holds in the output register; no new item is taken until the
// sequencer has loaded its result into the output register
module priority_preempt_state_sequencer #(
    parameter int NUM_STATES      = pps_pkg::NUM_STATES_DEF,
    parameter int NUM_TRANSITIONS = pps_pkg::NUM_TRANSITIONS_DEF,
    parameter int PRIORITY_BITS   = pps_pkg::PRIORITY_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    pps_item_if.sink                       item,
    pps_result_if.source                   result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pps_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [pps_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [pps_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);

    pps_pkg::pps_cfg_t      cfg;
    pps_pkg::pps_eval_req_t ev_req;
    pps_pkg::pps_eval_rsp_t ev_rsp;

    // configuration registers
    pps_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // shared evaluation unit
    pps_eval_unit #(
        .NUM_STATES    (NUM_STATES),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_eval (
        .cfg (cfg),
        .req (ev_req),
        .rsp (ev_rsp)
    );

    // sequencer
    pps_seq #(
        .NUM_TRANSITIONS (NUM_TRANSITIONS)
    ) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cfg    (cfg),
        .ev_req (ev_req),
        .ev_rsp (ev_rsp)
    );

endmodule

>>> sim/pps_seq_checker.sv
// checker for the priority preempt state sequencer: watches the request, result and
// configuration ports, predicts each result and compares it field by field
// depends on pps_pkg, pps_item_if and pps_result_if
module pps_seq_checker
    import pps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    pps_item_if                   item,
    pps_result_if                 result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    input  logic                  pready,
    output int                    fail_count,
    output int                    outstanding
);

    localparam int PRIO_W      = PRIORITY_BITS_DEF;
    localparam int SCAN_LIMIT  = (NUM_TRANSITIONS_DEF < TABLE_ENTRIES) ?
                                 NUM_TRANSITIONS_DEF : TABLE_ENTRIES;
    localparam int PRINT_LIMIT = 100;

    // one predicted result
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic               restart;
        logic               pend;
        logic [STATE_W-1:0] queued;
    } seq_outcome_t;

    // shadow copy of the configuration registers
    logic [PRIO_REG_W-1:0]  prio_cfg;
    logic [PRESENT_W-1:0]   present_cfg;
    logic [TRANS_REG_W-1:0] trans_lo_cfg;
    logic [TRANS_REG_W-1:0] trans_hi_cfg;
    logic [COUNT_W-1:0]     count_cfg;

    // shadow sequencer state
    logic [MODE_W-1:0]  cur_mode;
    logic               queue_flag;
    logic [STATE_W-1:0] queue_target;

    seq_outcome_t expected_outcomes[$];

    // print one line per mismatch, quiet after a while so a broken block cannot flood the log
    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (fail_count < PRINT_LIMIT)
            $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        fail_count++;
    endtask

    function automatic logic state_defined(input logic [MODE_W-1:0] s);
        return (s < MODE_W'(TABLE_ENTRIES)) && present_cfg[s[STATE_W-1:0]];
    endfunction

    // absent states and the none code read as priority zero
    function automatic logic [PRIO_W-1:0] prio_lookup(input logic [MODE_W-1:0] s);
        logic [PRIO_REG_W-1:0] shifted;
        int sh;
        sh = int'(s) * PRIO_W;
        if (!state_defined(s) || sh >= PRIO_REG_W)
            return '0;
        shifted = prio_cfg >> sh;
        return shifted[PRIO_W-1:0];
    endfunction

    function automatic logic switch_allowed(input logic [MODE_W-1:0] to);
        if (!state_defined(to))
            return 1'b0;
        return prio_lookup(to) >= prio_lookup(cur_mode);
    endfunction

    function automatic pps_entry_t table_entry(input int k);
        logic [TRANS_REG_W-1:0] word;
        word = (k < 4) ? trans_lo_cfg : trans_hi_cfg;
        return pps_entry_t'(word[(k % 4) * ENTRY_BITS +: ENTRY_BITS]);
    endfunction

    // apply one accepted request to the shadow state and give the result it causes
    task automatic advance_sequencer(input logic func, input logic [STATE_W-1:0] tgt,
                                     input logic frc, input logic fin,
                                     input logic [PRED_W-1:0] pred,
                                     output seq_outcome_t outcome);
        int scan_len;
        logic fired;
        logic go;
        logic restart;
        logic [MODE_W-1:0] tgt_mode;
        pps_entry_t e;
        restart  = 1'b0;
        fired    = 1'b0;
        tgt_mode = {1'b0, tgt};
        if (func == FUNC_REQUEST)
        begin
            // mode-change request: absent targets and unforced repeats are dropped
            if (state_defined(tgt_mode) && !(cur_mode == tgt_mode && !frc))
            begin
                if (frc)
                begin
                    cur_mode     = tgt_mode;
                    restart      = 1'b1;
                    queue_flag   = 1'b0;
                    queue_target = '0;
                end
                else if (!switch_allowed(tgt_mode))
                begin
                    queue_flag   = 1'b1;
                    queue_target = tgt;
                end
                else
                begin
                    cur_mode = tgt_mode;
                    restart  = 1'b1;
                end
            end
        end
        else
        begin
            // frame tick: first matching transition wins
            scan_len = int'(count_cfg);
            if (scan_len > SCAN_LIMIT)
                scan_len = SCAN_LIMIT;
            for (int k = 0; k < scan_len && !fired; k++)
            begin
                e  = table_entry(k);
                go = 1'b0;
                if ({1'b0, e.from} == cur_mode && !(e.gated && !pred[k]))
                begin
                    case (e.cond)
                        COND_ALWAYS:   go = 1'b1;
                        COND_FINISHED: go = fin;
                        COND_PRIORITY: go = switch_allowed({1'b0, e.to});
                        default:       go = 1'b0;
                    endcase
                end
                if (go)
                begin
                    cur_mode = {1'b0, e.to};
                    restart  = 1'b1;
                    fired    = 1'b1;
                end
            end
            // queued target fires once the animation is done, even onto the current mode
            if (!fired && queue_flag && fin)
            begin
                cur_mode     = {1'b0, queue_target};
                restart      = 1'b1;
                queue_flag   = 1'b0;
                queue_target = '0;
            end
        end
        outcome.mode    = cur_mode;
        outcome.restart = restart;
        outcome.pend    = queue_flag;
        outcome.queued  = queue_flag ? queue_target : '0;
    endtask

    // sample every port at the rising edge
    always @(posedge clk or negedge rst_n)
    begin : monitor
        seq_outcome_t got;
        seq_outcome_t want;
        if (!rst_n)
        begin
            prio_cfg     <= '0;
            present_cfg  <= '0;
            trans_lo_cfg <= '0;
            trans_hi_cfg <= '0;
            count_cfg    <= '0;
            cur_mode     = NO_MODE;
            queue_flag   = 1'b0;
            queue_target = '0;
            expected_outcomes.delete();
            fail_count   = 0;
            outstanding  = 0;
        end
        else
        begin
            // register writes, to be made at idle times only; the checker itself does not enforce it
            if (psel && penable && pwrite && pready)
            begin
                case (pps_reg_t'(paddr[5:3]))
                    REG_PRIORITIES: prio_cfg     <= pwdata[PRIO_REG_W-1:0];
                    REG_PRESENT:    present_cfg  <= pwdata[PRESENT_W-1:0];
                    REG_TRANS_LOW:  trans_lo_cfg <= pwdata[TRANS_REG_W-1:0];
                    REG_TRANS_HIGH: trans_hi_cfg <= pwdata[TRANS_REG_W-1:0];
                    REG_COUNT:      count_cfg    <= pwdata[COUNT_W-1:0];
                    default: ;
                endcase
            end
            // a result always belongs to an earlier request, so match it first
            if (result.valid && result.ready)
            begin
                got.mode    = result.active_state;
                got.restart = result.restart_animation;
                got.pend    = result.pending_valid;
                got.queued  = result.queued_state;
                if (expected_outcomes.size() == 0)
                    report_mismatch("result with no request waiting", 8'(got.mode), 8'd0);
                else
                begin
                    want = expected_outcomes.pop_front();
                    if (got.mode !== want.mode)
                        report_mismatch("active_state", 8'(got.mode), 8'(want.mode));
                    if (got.restart !== want.restart)
                        report_mismatch("restart_animation", 8'(got.restart),
                                        8'(want.restart));
                    if (got.pend !== want.pend)
                        report_mismatch("pending_valid", 8'(got.pend), 8'(want.pend));
                    if (got.queued !== want.queued)
                        report_mismatch("queued_state", 8'(got.queued), 8'(want.queued));
                end
            end
            if (item.valid && item.ready)
            begin
                advance_sequencer(item.func, item.target_state, item.force_request,
                                  item.anim_finished, item.predicate_ok, want);
                expected_outcomes = {expected_outcomes, want};
            end
            outstanding = expected_outcomes.size();
        end
    end

endmodule

>>> sim/tb_priority_preempt_state_sequencer.sv
// testbench top for the priority preempt state sequencer: drives directed and random
// requests under several table settings and idle patterns, and gives the verdict
// depends on pps_pkg, pps_item_if, pps_result_if, pps_seq_checker and the block itself
module tb_priority_preempt_state_sequencer;
    import pps_pkg::*;

    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 165;
    localparam int HOLD_CYCLES = 300;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int outstanding;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_len;

    pps_item_if   item_ch ();
    pps_result_if result_ch ();

    priority_preempt_state_sequencer u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    pps_seq_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_ch),
        .result      (result_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // pack one transition entry in register layout
    function automatic logic [ENTRY_BITS-1:0] make_entry(input logic [STATE_W-1:0] from,
                                                         input logic [STATE_W-1:0] to,
                                                         input pps_cond_t cond,
                                                         input logic gated);
        pps_entry_t e;
        e.from  = from;
        e.to    = to;
        e.cond  = cond;
        e.gated = gated;
        return e;
    endfunction

    // apb write: setup then access; called and left at a falling edge
    task automatic cfg_write(input pps_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // offer one request, with random idle cycles ahead of it; returns at a falling edge
    task automatic offer_request(input logic func, input logic [STATE_W-1:0] tgt,
                                 input logic frc, input logic fin,
                                 input logic [PRED_W-1:0] pred);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid = 1'b0;
            do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        item_ch.func          = func;
        item_ch.target_state  = tgt;
        item_ch.force_request = frc;
        item_ch.anim_finished = fin;
        item_ch.predicate_ok  = pred;
        item_ch.valid         = 1'b1;
        do @(posedge clk); while (!item_ch.ready);
        @(negedge clk);
    endtask

    // stop offering and wait until every predicted result has been handed over
    task automatic wait_drained();
        item_ch.valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // result side: random stalls, plus a long hold-off when asked
    initial
    begin : receiver
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_len > 0)
            begin
                result_ch.ready = 1'b0;
                hold_len--;
            end
            else
                result_ch.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin : stimulus
        logic [PRIO_REG_W-1:0]  prio;
        logic [PRESENT_W-1:0]   present;
        logic [TRANS_REG_W-1:0] words [2];
        logic [COUNT_W-1:0]     count;
        logic [STATE_W-1:0]     from;
        logic                   func;

        rst_n                 = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        item_ch.valid         = 1'b0;
        item_ch.func          = FUNC_REQUEST;
        item_ch.target_state  = '0;
        item_ch.force_request = 1'b0;
        item_ch.anim_finished = 1'b0;
        item_ch.predicate_ok  = '0;
        send_idle_pct         = 0;
        recv_idle_pct         = 0;
        hold_len              = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // all registers still zero: every state absent, empty table
        offer_request(FUNC_TICK, 3'd0, 1'b0, 1'b1, 8'hFF);
        offer_request(FUNC_REQUEST, 3'd7, 1'b1, 1'b0, 8'h00);
        wait_drained();

        // directed table: state 7 absent, count beyond the stored entries
        cfg_write(REG_PRIORITIES, 64'h2770_F531);
        cfg_write(REG_PRESENT, 64'h7F);
        cfg_write(REG_TRANS_LOW, {make_entry(3'd7, 3'd2, COND_ALWAYS, 1'b0),
                                  make_entry(3'd1, 3'd7, COND_FINISHED, 1'b0),
                                  make_entry(3'd1, 3'd7, COND_PRIORITY, 1'b0),
                                  make_entry(3'd0, 3'd1, COND_ALWAYS, 1'b1)});
        cfg_write(REG_TRANS_HIGH, {make_entry(3'd5, 3'd0, COND_FINISHED, 1'b1),
                                   make_entry(3'd3, 3'd5, COND_ALWAYS, 1'b0),
                                   make_entry(3'd2, 3'd4, COND_PRIORITY, 1'b0),
                                   make_entry(3'd2, 3'd3, COND_NEVER, 1'b0)});
        cfg_write(REG_COUNT, 64'hF);

        // absent target, first switch from none, unforced repeat, forced repeat
        offer_request(FUNC_REQUEST, 3'd7, 1'b0, 1'b0, 8'h00);
        offer_request(FUNC_REQUEST, 3'd2, 1'b0, 1'b0, 8'h00);
        offer_request(FUNC_REQUEST, 3'd2, 1'b0, 1'b0, 8'h00);
        offer_request(FUNC_REQUEST, 3'd2, 1'b1, 1'b0, 8'h00);
        // queue a lower priority target, then a normal switch keeps it queued
        offer_request(FUNC_REQUEST, 3'd1, 1'b0, 1'b0, 8'h00);
        offer_request(FUNC_REQUEST, 3'd5, 1'b0, 1'b0, 8'h00);
        // gated transition blocked; queue waits for finish, then fires
        offer_request(FUNC_TICK, 3'd0, 1'b0, 1'b0, 8'h00);
        offer_request(FUNC_TICK, 3'd0, 1'b0, 1'b1, 8'h00);
        // priority transition to an absent state never fires, finished one does
        offer_request(FUNC_TICK, 3'd0, 1'b0, 1'b0, 8'h00);
        offer_request(FUNC_TICK, 3'd0, 1'b0, 1'b1, 8'h00);
        offer_request(FUNC_TICK, 3'd0, 1'b0, 1'b0, 8'h00);
        // never condition and failing priority condition
        offer_request(FUNC_REQUEST, 3'd0, 1'b0, 1'b0, 8'h00);
        offer_request(FUNC_TICK, 3'd0, 1'b0, 1'b0, 8'hFF);
        // forced switch clears the queue
        offer_request(FUNC_REQUEST, 3'd0, 1'b1, 1'b0, 8'h00);
        offer_request(FUNC_REQUEST, 3'd3, 1'b0, 1'b0, 8'h00);
        offer_request(FUNC_REQUEST, 3'd2, 1'b0, 1'b0, 8'h00);
        offer_request(FUNC_TICK, 3'd0, 1'b0, 1'b1, 8'h00);
        // queued target equal to the mode still fires
        offer_request(FUNC_REQUEST, 3'd0, 1'b0, 1'b0, 8'h00);
        offer_request(FUNC_TICK, 3'd0, 1'b0, 1'b1, 8'h80);
        offer_request(FUNC_TICK, 3'd0, 1'b0, 1'b1, 8'h00);
        offer_request(FUNC_TICK, 3'd0, 1'b0, 1'b0, 8'h01);

        // random phases, each with its own table and idle pattern
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_drained();
            prio    = $urandom();
            present = ($urandom_range(1) == 1) ? 8'hFF
                                               : (8'($urandom_range(255)) | (8'h1 << $urandom_range(7)));
            words[0] = '0;
            words[1] = '0;
            for (int k = 0; k < TABLE_ENTRIES; k++)
            begin
                do from = 3'($urandom_range(7)); while (!present[from]);
                words[k / 4][(k % 4) * ENTRY_BITS +: ENTRY_BITS] =
                    make_entry(from, 3'($urandom_range(7)),
                               pps_cond_t'(($urandom_range(9) == 0) ? 3 : $urandom_range(2)),
                               1'($urandom_range(1)));
            end
            count = ($urandom_range(3) == 0) ? 4'($urandom_range(9, 15))
                                             : 4'($urandom_range(1, 8));
            case (phase)
                2:
                begin
                    // everything at its maximum
                    prio     = '1;
                    present  = '1;
                    words[0] = '1;
                    words[1] = '1;
                    count    = '1;
                end
                4:
                begin
                    // flat priorities, no transitions: no request is held back by priority, ticks scan no entries
                    prio  = '0;
                    count = '0;
                end
                7: count = 4'(TABLE_ENTRIES);
                default: ;
            endcase
            cfg_write(REG_PRIORITIES, 64'(prio));
            cfg_write(REG_PRESENT, 64'(present));
            cfg_write(REG_TRANS_LOW, 64'(words[0]));
            cfg_write(REG_TRANS_HIGH, 64'(words[1]));
            cfg_write(REG_COUNT, 64'(count));

            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 53;
                    recv_idle_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 53;
                end
                default:
                begin
                    send_idle_pct = 14;
                    recv_idle_pct = 14;
                end
            endcase

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // long receiver hold-off while requests keep coming
                if (phase == 0 && n == 40)
                    hold_len = HOLD_CYCLES;
                func = ($urandom_range(99) < 45) ? FUNC_REQUEST : FUNC_TICK;
                offer_request(func, 3'($urandom_range(7)), ($urandom_range(99) < 15),
                              1'($urandom_range(1)), 8'($urandom_range(255)));
            end
        end

        wait_drained();
        repeat (16) @(negedge clk);
        if (fail_count == 0)
            $display("tb_priority_preempt_state_sequencer passed");
        else
            $display("tb_priority_preempt_state_sequencer failed");
        $finish;
    end

    initial
    begin : watchdog
        #2000000;
        $display("tb_priority_preempt_state_sequencer failed");
        $finish;
    end

endmodule

>>> files.f
sv/pps_pkg.sv
sv/pps_item_if.sv
sv/pps_result_if.sv
sv/pps_cfg_regs.sv
sv/pps_eval_unit.sv
sv/pps_seq.sv
sv/priority_preempt_state_sequencer.sv
sim/pps_seq_checker.sv
sim/tb_priority_preempt_state_sequencer.sv
